// ===== sv/cpre_pkg.sv =====
// ----------------------------------------------------------------------------
// cpre_pkg
// Types and constants shared by the control plane run extractor.
// ----------------------------------------------------------------------------
package cpre_pkg;

  localparam int WIDTH_W   = 13;
  localparam int OFFSET_W  = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 14;
  localparam int MAX_RUNS  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 2'd2;

  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd4096;
  localparam logic [WIDTH_W-1:0] PLANE_WIDTH_RST = 13'd4096;

  typedef struct packed {
    logic [WIDTH_W-1:0] run_len;
    logic               run_inside;
    logic               line_done;
  } run_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] plane_index;
    logic [WIDTH_W-1:0] image_position;
    logic               run_polarity;
    logic [WIDTH_W-1:0] run_accumulated;
  } line_state_t;

  typedef struct packed {
    line_state_t        state;
    run_t [MAX_RUNS-1:0] runs;
    logic [1:0]         count;
  } step_out_t;

endpackage

// ===== sv/cpre_if.sv =====
// ----------------------------------------------------------------------------
// cpre interfaces
// Valid/ready channels for plane bits, runs and register writes.
// ----------------------------------------------------------------------------
interface cpre_item_if;
  logic valid;
  logic ready;
  logic line_pass;
  logic plane_bit;

  modport source (output valid, output line_pass, output plane_bit, input ready);
  modport sink   (input valid, input line_pass, input plane_bit, output ready);
endinterface

interface cpre_run_if;
  logic        valid;
  logic        ready;
  logic [12:0] run_len;
  logic        run_inside;
  logic        line_done;

  modport source (output valid, output run_len, output run_inside, output line_done,
                  input ready);
  modport sink   (input valid, input run_len, input run_inside, input line_done,
                  output ready);
endinterface

interface cpre_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/cpre_step.sv =====
// ----------------------------------------------------------------------------
// cpre_step
// Run state update for one plane bit: next line state plus up to three runs.
// ----------------------------------------------------------------------------
module cpre_step
  import cpre_pkg::*;
(
  input  logic [WIDTH_W-1:0]         img_w,
  input  logic [WIDTH_W-1:0]         pln_w,
  input  logic signed [OFFSET_W-1:0] x_off,
  input  logic                       line_pass,
  input  logic                       plane_bit,
  input  line_state_t                cur,
  output step_out_t                  step
);

  logic signed [OFFSET_W:0] x_e;
  logic signed [OFFSET_W:0] w_e;
  logic signed [OFFSET_W:0] pw_e;
  logic signed [OFFSET_W:0] p;
  logic [WIDTH_W-1:0]       lead;
  logic [WIDTH_W:0]         idx_inc;
  logic                     no_overlap;
  logic                     covered;
  logic [WIDTH_W-1:0]       acc;
  logic [WIDTH_W-1:0]       pos;
  logic [WIDTH_W-1:0]       pad;
  logic                     pol;
  logic [1:0]               n;
  run_t [MAX_RUNS-1:0]      runs;
  line_state_t              start;

  always_comb begin
    x_e  = {x_off[OFFSET_W-1], x_off};
    w_e  = {2'b00, img_w};
    pw_e = {2'b00, pln_w};
    p    = x_e + {2'b00, cur.plane_index};
    lead = (x_e > 0) ? x_off[WIDTH_W-1:0] : '0;

    start.plane_index     = '0;
    start.image_position  = lead;
    start.run_polarity    = 1'b0;
    start.run_accumulated = lead;

    no_overlap = line_pass || ((x_e + pw_e) <= 0) || (x_e >= w_e);
    idx_inc    = {1'b0, cur.plane_index} + 14'd1;

    acc     = cur.run_accumulated;
    pos     = cur.image_position;
    pol     = cur.run_polarity;
    pad     = '0;
    n       = '0;
    runs    = '0;
    covered = 1'b0;

    step.state = cur;

    if (no_overlap) begin
      runs[0]    = '{run_len: img_w, run_inside: 1'b0, line_done: 1'b1};
      n          = 2'd1;
      step.state = start;
    end else begin
      covered = (p >= 0) && (p < w_e) && (pos < img_w);
      if (covered) begin
        if ((acc != '0) && (plane_bit != pol)) begin
          runs[n] = '{run_len: acc, run_inside: pol, line_done: 1'b0};
          n       = n + 2'd1;
          acc     = '0;
        end
        pol = plane_bit;
        acc = acc + 13'd1;
        pos = pos + 13'd1;
        if (pos >= img_w) begin
          runs[n] = '{run_len: acc, run_inside: pol, line_done: 1'b1};
          n       = n + 2'd1;
        end
      end
      if (idx_inc >= {1'b0, pln_w}) begin
        if (pos < img_w) begin
          pad = img_w - pos;
          if (!pol) begin
            runs[n] = '{run_len: acc + pad, run_inside: 1'b0, line_done: 1'b1};
            n       = n + 2'd1;
          end else begin
            runs[n] = '{run_len: acc, run_inside: 1'b1, line_done: 1'b0};
            n       = n + 2'd1;
            runs[n] = '{run_len: pad, run_inside: 1'b0, line_done: 1'b1};
            n       = n + 2'd1;
          end
        end
        step.state = start;
      end else begin
        step.state.plane_index     = idx_inc[WIDTH_W-1:0];
        step.state.image_position  = pos;
        step.state.run_polarity    = pol;
        step.state.run_accumulated = acc;
      end
    end

    step.runs  = runs;
    step.count = n;
  end

endmodule

// ===== sv/control_plane_run_extractor.sv =====
// ----------------------------------------------------------------------------
// control_plane_run_extractor
// Turns a 1-bit control plane line into inside/outside runs over an image line.
// ----------------------------------------------------------------------------
// One plane bit (or line pass) per transaction on item; runs leave on run as
// length, inside flag and line_done on the final run of each image line. An
// item is taken every cycle as long as its runs drain: it passes an input
// register and the combinational run logic, and lands in a three-entry run
// register that the run port empties one run per cycle while the sink is ready;
// a new item waits until the run register is empty or its last run leaves.
// Registers on cfg (0 image_width, 1 plane_width, 2 x_offset) restart the current
// line; zero widths count as 1, widths above min(MAX_WIDTH, 8191) as that cap.
// ----------------------------------------------------------------------------
module control_plane_run_extractor
  import cpre_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic          clk,
  input  logic          rst,
  cpre_item_if.sink     item,
  cpre_run_if.source    run,
  cpre_cfg_if.sink      cfg
);

  localparam int                 CAP   = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam logic [WIDTH_W-1:0] CAP_W = WIDTH_W'(CAP);

  logic [WIDTH_W-1:0]         image_width;
  logic [WIDTH_W-1:0]         plane_width;
  logic signed [OFFSET_W-1:0] x_offset;
  logic [WIDTH_W-1:0]         img_w;
  logic [WIDTH_W-1:0]         pln_w;

  line_state_t         line_state;
  logic                in_valid;
  logic                in_pass;
  logic                in_bit;
  run_t [MAX_RUNS-1:0] runs;
  logic [1:0]          run_count;

  step_out_t step;
  logic      pop;
  logic      grp_free;
  logic      move;
  logic      cfg_wr;
  line_state_t restart;

  always_comb begin
    img_w = (image_width == '0) ? 13'd1 : ((image_width > CAP_W) ? CAP_W : image_width);
    pln_w = (plane_width == '0) ? 13'd1 : ((plane_width > CAP_W) ? CAP_W : plane_width);
  end

  cpre_step u_step (
    .img_w     (img_w),
    .pln_w     (pln_w),
    .x_off     (x_offset),
    .line_pass (in_pass),
    .plane_bit (in_bit),
    .cur       (line_state),
    .step      (step)
  );

  assign pop      = run.valid && run.ready;
  assign grp_free = (run_count == 2'd0) || ((run_count == 2'd1) && pop);
  assign move     = in_valid && grp_free;

  assign item.ready = !rst && (!in_valid || move);
  assign cfg.ready  = !rst;
  assign cfg_wr     = cfg.valid && !rst && (cfg.index == CFG_IMAGE_WIDTH ||
                                            cfg.index == CFG_PLANE_WIDTH ||
                                            cfg.index == CFG_X_OFFSET);

  // a positive x_offset, new or current, sets the leading outside pixels of the restarted line
  always_comb begin
    restart = '0;
    if (cfg.index == CFG_X_OFFSET) begin
      if (!cfg.data[OFFSET_W-1] && (cfg.data[OFFSET_W-2:0] != '0)) begin
        restart.image_position  = cfg.data[WIDTH_W-1:0];
        restart.run_accumulated = cfg.data[WIDTH_W-1:0];
      end
    end else if (!x_offset[OFFSET_W-1] && (x_offset != '0)) begin
      restart.image_position  = x_offset[WIDTH_W-1:0];
      restart.run_accumulated = x_offset[WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RST;
      plane_width <= PLANE_WIDTH_RST;
      x_offset    <= '0;
      line_state  <= '0;
    end else if (cfg_wr) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH: image_width <= cfg.data[WIDTH_W-1:0];
        CFG_PLANE_WIDTH: plane_width <= cfg.data[WIDTH_W-1:0];
        CFG_X_OFFSET:    x_offset    <= cfg.data;
        default:         ;
      endcase
      line_state <= restart;
    end else if (move) begin
      line_state <= step.state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_pass <= item.line_pass;
      in_bit  <= item.plane_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
    end else if (move) begin
      run_count <= step.count;
    end else if (pop) begin
      run_count <= run_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      runs <= step.runs;
    end else if (pop) begin
      runs[0] <= runs[1];
      runs[1] <= runs[2];
    end
  end

  assign run.valid      = (run_count != 2'd0);
  assign run.run_len    = runs[0].run_len;
  assign run.run_inside = runs[0].run_inside;
  assign run.line_done  = runs[0].line_done;

endmodule

// ===== bench/cpre_run_checker.sv =====
// ----------------------------------------------------------------------------
// cpre_run_checker
// Watches the plane bit, run and register channels of the control plane run
// extractor, predicts the runs of every accepted plane bit or line pass, and
// compares each run transaction in order against the oldest prediction.
// ----------------------------------------------------------------------------
module cpre_run_checker
  import cpre_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic  clk,
  input  logic  rst,
  cpre_item_if  item,
  cpre_run_if   run,
  cpre_cfg_if   cfg,
  output int    errors,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        [WIDTH_W-1:0]  img_w;
  logic        [WIDTH_W-1:0]  pln_w;
  logic signed [OFFSET_W-1:0] x_off;

  logic [WIDTH_W-1:0] plane_idx;
  logic [WIDTH_W-1:0] img_pos;
  logic               run_pol;
  logic [WIDTH_W-1:0] run_len_acc;

  run_t runs_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int clamp_width(input logic [WIDTH_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_WIDTH) return MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic void restart_line();
    int lead;
    lead = (x_off > 0) ? int'(x_off) : 0;
    plane_idx   = '0;
    img_pos     = lead[WIDTH_W-1:0];
    run_len_acc = lead[WIDTH_W-1:0];
    run_pol     = 1'b0;
  endfunction

  function automatic void push_run(input int len, input logic is_in, input logic done);
    run_t r;
    r.run_len    = len[WIDTH_W-1:0];
    r.run_inside = is_in;
    r.line_done  = done;
    runs_due.push_back(r);
  endfunction

  function automatic void predict_runs(input logic pass, input logic pbit);
    int w, pw, x, p, pad;
    w  = clamp_width(img_w);
    pw = clamp_width(pln_w);
    x  = x_off;
    if (pass || x + pw <= 0 || x >= w) begin
      restart_line();
      push_run(w, 1'b0, 1'b1);
      return;
    end
    p = x + int'(plane_idx);
    if (p >= 0 && p < w && int'(img_pos) < w) begin
      if (run_len_acc != '0 && pbit != run_pol) begin
        push_run(int'(run_len_acc), run_pol, 1'b0);
        run_len_acc = '0;
      end
      run_pol     = pbit;
      run_len_acc = run_len_acc + 1'b1;
      img_pos     = img_pos + 1'b1;
      if (int'(img_pos) >= w) push_run(int'(run_len_acc), run_pol, 1'b1);
    end
    if (int'(plane_idx) + 1 >= pw) begin
      if (int'(img_pos) < w) begin
        pad = w - int'(img_pos);
        if (!run_pol) begin
          push_run(int'(run_len_acc) + pad, 1'b0, 1'b1);
        end else begin
          push_run(int'(run_len_acc), 1'b1, 1'b0);
          push_run(pad, 1'b0, 1'b1);
        end
      end
      restart_line();
    end else begin
      plane_idx = plane_idx + 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    run_t got, want;
    if (rst) begin
      img_w = IMAGE_WIDTH_RST;
      pln_w = PLANE_WIDTH_RST;
      x_off = '0;
      restart_line();
      runs_due.delete();
    end else begin
      if (run.valid && run.ready) begin
        got.run_len    = run.run_len;
        got.run_inside = run.run_inside;
        got.line_done  = run.line_done;
        if (runs_due.size() == 0) begin
          errors++;
          $display("%0t run transaction with none expected: got len %0d in %0b done %0b",
                   $time, got.run_len, got.run_inside, got.line_done);
        end else begin
          want = runs_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t run mismatch: want len %0d in %0b done %0b, got %0d %0b %0b",
                     $time, want.run_len, want.run_inside, want.line_done,
                     got.run_len, got.run_inside, got.line_done);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_IMAGE_WIDTH: begin
            img_w = cfg.data[WIDTH_W-1:0];
            restart_line();
          end
          CFG_PLANE_WIDTH: begin
            pln_w = cfg.data[WIDTH_W-1:0];
            restart_line();
          end
          CFG_X_OFFSET: begin
            x_off = cfg.data;
            restart_line();
          end
          default: ;
        endcase
      end
      if (item.valid && item.ready) predict_runs(item.line_pass, item.plane_bit);
    end
    pending <= runs_due.size();
  end

endmodule

// ===== bench/tb_control_plane_run_extractor.sv =====
// ----------------------------------------------------------------------------
// tb_control_plane_run_extractor
// Drives plane bits, line passes and register writes into the control plane
// run extractor: a directed part over the special cases and register extremes,
// then random lines under several settings with random sender and receiver
// idling, one long receiver hold-off, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_control_plane_run_extractor;
  timeunit 1ns;
  timeprecision 1ps;
  import cpre_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 45;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles         = 0;
  int   send_idle_pct  = 24;
  int   recv_stall_pct = 80;
  int   holds_asked    = 0;
  logic last_bit;

  cpre_item_if item_ch ();
  cpre_run_if  run_ch ();
  cpre_cfg_if  cfg_ch ();

  control_plane_run_extractor #(.MAX_WIDTH(4096)) i_dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .run  (run_ch),
    .cfg  (cfg_ch)
  );

  cpre_run_checker #(.MAX_WIDTH(4096)) i_checker (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .run     (run_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_control_plane_run_extractor: done, errors");
      $finish;
    end
  end

  // run sink: random stalls, plus a long hold-off when asked
  initial begin
    int hold_left;
    int holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    run_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        run_ch.ready <= 1'b0;
      end else begin
        run_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic pass, input logic pbit);
    item_ch.valid     <= 1'b1;
    item_ch.line_pass <= pass;
    item_ch.plane_bit <= pbit;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    if ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // pattern is sent LSB first
  task automatic send_bits(input logic [15:0] pattern, input int count);
    for (int k = 0; k < count; k++) send_item(1'b0, pattern[k]);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic configure(input logic [CFG_DAT_W-1:0] iw, input logic [CFG_DAT_W-1:0] pw,
                           input logic [CFG_DAT_W-1:0] xo);
    settle();
    write_reg(CFG_IMAGE_WIDTH, iw);
    write_reg(CFG_PLANE_WIDTH, pw);
    write_reg(CFG_X_OFFSET, xo);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int iw, pw, span, xo;
    iw   = ($urandom_range(5) == 0) ? 4096 : $urandom_range(1, 16);
    pw   = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    span = (iw > 20) ? 20 : iw;
    xo   = int'($urandom_range(0, span + pw + 4)) - pw - 2;
    configure(iw[CFG_DAT_W-1:0], pw[CFG_DAT_W-1:0], xo[CFG_DAT_W-1:0]);
    repeat (n_items) begin
      if ($urandom_range(99) < 6) begin
        send_item(1'b1, 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(99) >= 70) last_bit = ~last_bit;
        send_item(1'b0, last_bit);
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.line_pass = 1'b0;
    item_ch.plane_bit = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_IMAGE_WIDTH;
    cfg_ch.data       = '0;
    last_bit          = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: full-width passes around a partial 4096-pixel line
    send_item(1'b1, 1'b0);
    send_bits(16'b1011, 4);
    send_item(1'b1, 1'b1);

    // leading offset, plane ends inside before the image edge
    configure(14'd10, 14'd4, 14'd3);
    send_bits(16'b1101, 4);
    send_bits(16'b11, 2);
    settle();
    write_reg(CFG_SPARE, 14'h2AAA);
    cfg_ch.valid <= 1'b0;
    send_bits(16'b00, 2);

    // bits left of the image skipped, bits right of it ignored
    configure(14'd5, 14'd8, -14'sd2);
    send_bits(16'b0110_0101, 8);

    // zero widths, oversized widths, and no horizontal overlap
    configure(14'd0, 14'd0, 14'd0);
    send_item(1'b0, 1'b1);
    configure(14'h3FFF, 14'd3, 14'h2000);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    configure(14'd4096, 14'd4096, 14'd4096);
    send_item(1'b0, 1'b1);
    configure(14'h2005, 14'd4, -14'sd4);
    send_item(1'b0, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = (mode == 0) ? 24 : (mode == 1) ? 80 : 0;
      recv_stall_pct = (mode == 0) ? 80 : (mode == 1) ? 24 : 0;
      if (mode == 2) holds_asked++;
      repeat (3) random_phase(PHASE_ITEMS);
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb_control_plane_run_extractor: done, clean");
    end else begin
      $display("tb_control_plane_run_extractor: done, errors");
    end
    $finish;
  end

endmodule
